FILE: sv/stvm_pkg.sv
// ----------------------------------------------------------------------------
// stvm_pkg
// Shared types, codes and widths for the signature table value matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package stvm_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int LIST_DEPTH_DEF  = 8;

    localparam int ID_W       = 16;
    localparam int VAL_W      = 32;
    localparam int FUZZ_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MODE_W     = 3;

    // result queue between the walk pipeline and the output port
    localparam int RQ_DEPTH = 4;

    localparam logic signed [VAL_W-1:0] SENTINEL     = -32'sd1;
    localparam logic signed [VAL_W-1:0] FLAG_ZERO    = 32'sd0;
    localparam logic signed [VAL_W-1:0] FLAG_NONZERO = 32'sd1;
    localparam logic signed [VAL_W-1:0] STRAT_RANDOM = 32'sd0;
    localparam logic signed [VAL_W-1:0] STRAT_INCR   = 32'sd1;
    localparam logic signed [VAL_W-1:0] STRAT_ZERO   = 32'sd2;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_OBSERVE = 2'd2
    } cmd_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ZNZ      = 3'd0,
        MODE_ZNZ_ORIG = 3'd1,
        MODE_VALUE    = 3'd2,
        MODE_RANGE    = 3'd3,
        MODE_INTERVAL = 3'd4,
        MODE_LIST     = 3'd5,
        MODE_STRATEGY = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        V_NO_MATCH = 2'd0,
        V_MATCH    = 2'd1,
        V_NONE     = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_DUPLICATE  = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_LIST_FULL  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_MODE = 2'd0,
        CFG_FUZZY      = 2'd1,
        CFG_THRESHOLD  = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_DECIDE,
        S_INS_SHIFT,
        S_INS_FIN,
        S_APP_READ,
        S_APP_WRITE,
        S_OBSERVE,
        S_STATUS
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        verdict_t        verdict;
        logic            has_entry;
        status_t         status;
        logic            last;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/signature_table_value_matcher.sv
// Insert: searches the n stored ids and decides (a duplicate id or a full table is
//   rejected), then moves m entries in the rank RAM and writes the new rank; append reads
//   and rewrites the last inserted entry; observe gives one verdict per cycle while the
//   result queue has room, one per stored entry (rank RAM then entry RAM).
// One item is in work at a time; finished results wait in a 4-deep queue at the output.
// Reset clears the control state and empties the table; the RAMs need no clearing pass.
// ----------------------------------------------------------------------------
// signature_table_value_matcher
// Sorted signature table in RAM; classifies observed values entry by entry.
// ----------------------------------------------------------------------------
`default_nettype none

module signature_table_value_matcher
    import stvm_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int LIST_DEPTH  = LIST_DEPTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [1:0]              command,
    input  wire logic [ID_W-1:0]         entry_id,
    input  wire logic signed [VAL_W-1:0] sig_low,
    input  wire logic signed [VAL_W-1:0] sig_high,
    input  wire logic signed [VAL_W-1:0] list_value,
    input  wire logic signed [VAL_W-1:0] observed,
    input  wire logic signed [VAL_W-1:0] original,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [ID_W-1:0]              result_id,
    output logic [1:0]                   verdict,
    output logic                         has_entry,
    output logic [1:0]                   status,
    output logic                         last,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LCNT_W = $clog2(LIST_DEPTH + 1);
    localparam int SIG_W  = ID_W + 2 * VAL_W + LCNT_W;
    localparam int ROW_W  = LIST_DEPTH * VAL_W;
    localparam int RQC_W  = $clog2(RQ_DEPTH + 1);
    localparam int INF_W  = RQC_W + 1;

    // control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SLOT_W-1:0]  last_slot_reg, last_slot_next;
    mode_t              mode_reg, mode_next;
    logic [FUZZ_W-1:0]  delta_reg, delta_next;
    logic [FUZZ_W-1:0]  thr_reg, thr_next;
    logic               sv_reg, sv_next;
    logic               shv_reg, shv_next;
    logic               p1_vld_reg, p1_vld_next;
    logic               p2_vld_reg, p2_vld_next;

    // item and walk payload
    logic [ID_W-1:0]         id_reg, id_next;
    logic signed [VAL_W-1:0] low_reg, low_next;
    logic signed [VAL_W-1:0] high_reg, high_next;
    logic signed [VAL_W-1:0] lval_reg, lval_next;
    logic signed [VAL_W-1:0] obs_reg, obs_next;
    logic signed [VAL_W-1:0] orig_reg, orig_next;
    logic [CNT_W-1:0]        scan_reg, scan_next;
    logic                    dup_reg, dup_next;
    logic [CNT_W-1:0]        less_reg, less_next;
    logic [CNT_W-1:0]        shift_reg, shift_next;
    logic [SLOT_W-1:0]       sh_addr_reg, sh_addr_next;
    logic [CNT_W-1:0]        rank_reg, rank_next;
    logic                    p1_last_reg, p1_last_next;
    logic                    p2_last_reg, p2_last_next;
    logic [ID_W-1:0]         st_id_reg, st_id_next;
    status_t                 st_code_reg, st_code_next;

    // RAM ports
    logic              sig_we, sig_re;
    logic [SLOT_W-1:0] sig_waddr, sig_raddr;
    logic [SIG_W-1:0]  sig_wdata, sig_rdata;
    logic              lst_we, lst_re;
    logic [SLOT_W-1:0] lst_waddr, lst_raddr;
    logic [ROW_W-1:0]  lst_wdata, lst_rdata;
    logic              ord_we, ord_re;
    logic [SLOT_W-1:0] ord_waddr, ord_raddr;
    logic [SLOT_W-1:0] ord_wdata, ord_rdata;

    logic [ID_W-1:0]         sig_id;
    logic signed [VAL_W-1:0] sig_lo;
    logic signed [VAL_W-1:0] sig_hi;
    logic [LCNT_W-1:0]       sig_cnt;

    logic             in_accept;
    cmd_t             cmd_in;
    logic             scan_issue;
    logic             shift_issue;
    logic             obs_issue;
    logic             rq_room;
    logic             list_full;
    logic             ins_reject;
    logic [CNT_W-1:0] shift_m1;
    logic [INF_W-1:0] inflight;
    logic [ROW_W-1:0] new_row;

    result_t          rq_push_data;
    logic             rq_push;
    result_t          rq_head;
    logic             rq_not_empty;
    logic [RQC_W-1:0] rq_count;
    verdict_t         judged;

    assign cmd_in    = cmd_t'(command);
    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    assign sig_id  = sig_rdata[SIG_W-1 -: ID_W];
    assign sig_lo  = sig_rdata[SIG_W-ID_W-1 -: VAL_W];
    assign sig_hi  = sig_rdata[LCNT_W+VAL_W-1 -: VAL_W];
    assign sig_cnt = sig_rdata[LCNT_W-1:0];

    assign list_full  = (sig_cnt >= LCNT_W'(LIST_DEPTH));
    assign ins_reject = dup_reg || (count_reg == CNT_W'(TABLE_DEPTH));
    assign shift_m1   = shift_reg - CNT_W'(1);

    // results already queued plus those still in the read pipeline
    assign inflight = INF_W'(rq_count) + INF_W'(p1_vld_reg) + INF_W'(p2_vld_reg);
    assign rq_room  = (inflight < INF_W'(RQ_DEPTH));

    assign scan_issue  = (state_reg == S_INS_SCAN) && (scan_reg < count_reg);
    assign shift_issue = (state_reg == S_INS_SHIFT) && (shift_reg > less_reg);
    assign obs_issue   = (state_reg == S_OBSERVE) && (rank_reg < count_reg) && rq_room;

    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            new_row[i*VAL_W +: VAL_W] = (LCNT_W'(i) == sig_cnt) ? lval_reg
                                                                : lst_rdata[i*VAL_W +: VAL_W];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (cmd_in)
                        CMD_INSERT:  state_next = S_INS_SCAN;
                        CMD_APPEND:  state_next = (count_reg == '0) ? S_STATUS : S_APP_READ;
                        CMD_OBSERVE: state_next = (count_reg == '0) ? S_STATUS : S_OBSERVE;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_INS_SCAN:
            begin
                if ((scan_reg == count_reg) && !sv_reg)
                begin
                    state_next = S_INS_DECIDE;
                end
            end
            S_INS_DECIDE:
            begin
                state_next = ins_reject ? S_STATUS : S_INS_SHIFT;
            end
            S_INS_SHIFT:
            begin
                if ((shift_reg == less_reg) && !shv_reg)
                begin
                    state_next = S_INS_FIN;
                end
            end
            S_INS_FIN:   state_next = S_STATUS;
            S_APP_READ:  state_next = S_APP_WRITE;
            S_APP_WRITE: state_next = S_STATUS;
            S_OBSERVE:
            begin
                if ((rank_reg == count_reg) && !p1_vld_reg && !p2_vld_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_STATUS:
            begin
                if (rq_count < RQC_W'(RQ_DEPTH))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // FSM outputs: RAM strobes, queue push, input stall
    always_comb
    begin
        in_stall = (state_reg != S_IDLE);

        sig_re    = scan_issue || (state_reg == S_APP_READ) || p1_vld_reg;
        sig_raddr = ord_rdata;
        if (scan_issue)
        begin
            sig_raddr = scan_reg[SLOT_W-1:0];
        end
        else if (state_reg == S_APP_READ)
        begin
            sig_raddr = last_slot_reg;
        end

        lst_re    = (state_reg == S_APP_READ) || p1_vld_reg;
        lst_raddr = (state_reg == S_APP_READ) ? last_slot_reg : ord_rdata;

        ord_re    = shift_issue || obs_issue;
        ord_raddr = shift_issue ? shift_m1[SLOT_W-1:0] : rank_reg[SLOT_W-1:0];

        ord_we    = 1'b0;
        ord_waddr = sh_addr_reg;
        ord_wdata = ord_rdata;
        if (shv_reg)
        begin
            ord_we = 1'b1;
        end
        else if (state_reg == S_INS_FIN)
        begin
            ord_we    = 1'b1;
            ord_waddr = less_reg[SLOT_W-1:0];
            ord_wdata = count_reg[SLOT_W-1:0];
        end

        sig_we    = 1'b0;
        sig_waddr = last_slot_reg;
        sig_wdata = {sig_rdata[SIG_W-1:LCNT_W], sig_cnt + LCNT_W'(1)};
        lst_we    = 1'b0;
        lst_waddr = last_slot_reg;
        lst_wdata = new_row;
        if ((state_reg == S_INS_DECIDE) && !ins_reject)
        begin
            sig_we    = 1'b1;
            sig_waddr = count_reg[SLOT_W-1:0];
            sig_wdata = {id_reg, low_reg, high_reg, {LCNT_W{1'b0}}};
        end
        else if ((state_reg == S_APP_WRITE) && !list_full)
        begin
            sig_we = 1'b1;
            lst_we = 1'b1;
        end

        rq_push              = 1'b0;
        rq_push_data.id        = st_id_reg;
        rq_push_data.verdict   = V_NONE;
        rq_push_data.has_entry = 1'b0;
        rq_push_data.status    = st_code_reg;
        rq_push_data.last      = 1'b1;
        if (p2_vld_reg)
        begin
            rq_push                = 1'b1;
            rq_push_data.id        = sig_id;
            rq_push_data.verdict   = judged;
            rq_push_data.has_entry = 1'b1;
            rq_push_data.status    = ST_OK;
            rq_push_data.last      = p2_last_reg;
        end
        else if ((state_reg == S_STATUS) && (rq_count < RQC_W'(RQ_DEPTH)))
        begin
            rq_push = 1'b1;
        end
    end

    // datapath next values
    always_comb
    begin
        count_next     = count_reg;
        last_slot_next = last_slot_reg;
        mode_next      = mode_reg;
        delta_next     = delta_reg;
        thr_next       = thr_reg;
        id_next        = id_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        lval_next      = lval_reg;
        obs_next       = obs_reg;
        orig_next      = orig_reg;
        scan_next      = scan_reg;
        dup_next       = dup_reg;
        less_next      = less_reg;
        shift_next     = shift_reg;
        rank_next      = rank_reg;
        st_id_next     = st_id_reg;
        st_code_next   = st_code_reg;

        sv_next      = scan_issue;
        shv_next     = shift_issue;
        sh_addr_next = shift_reg[SLOT_W-1:0];
        p1_vld_next  = obs_issue;
        p1_last_next = ((rank_reg + CNT_W'(1)) == count_reg);
        p2_vld_next  = p1_vld_reg;
        p2_last_next = p1_last_reg;

        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MATCH_MODE: mode_next  = mode_t'(cfg_data[MODE_W-1:0]);
                CFG_FUZZY:      delta_next = cfg_data[FUZZ_W-1:0];
                CFG_THRESHOLD:  thr_next   = cfg_data[FUZZ_W-1:0];
                default:        mode_next  = mode_reg;
            endcase
        end

        if (in_accept)
        begin
            id_next      = entry_id;
            low_next     = sig_low;
            high_next    = sig_high;
            lval_next    = list_value;
            obs_next     = observed;
            orig_next    = original;
            scan_next    = '0;
            dup_next     = 1'b0;
            less_next    = '0;
            rank_next    = '0;
            st_id_next   = (cmd_in == CMD_INSERT) ? entry_id : '0;
            st_code_next = (cmd_in == CMD_APPEND) ? ST_LIST_FULL : ST_OK;
        end

        if (scan_issue)
        begin
            scan_next = scan_reg + CNT_W'(1);
        end
        if (sv_reg)
        begin
            if (sig_id == id_reg)
            begin
                dup_next = 1'b1;
            end
            if (sig_id < id_reg)
            begin
                less_next = less_reg + CNT_W'(1);
            end
        end

        if (state_reg == S_INS_DECIDE)
        begin
            shift_next = count_reg;
            if (dup_reg)
            begin
                st_code_next = ST_DUPLICATE;
            end
            else if (count_reg == CNT_W'(TABLE_DEPTH))
            begin
                st_code_next = ST_TABLE_FULL;
            end
        end
        if (shift_issue)
        begin
            shift_next = shift_m1;
        end

        if (state_reg == S_INS_FIN)
        begin
            count_next     = count_reg + CNT_W'(1);
            last_slot_next = count_reg[SLOT_W-1:0];
        end

        if (state_reg == S_APP_WRITE)
        begin
            st_id_next   = sig_id;
            st_code_next = list_full ? ST_LIST_FULL : ST_OK;
        end

        if (obs_issue)
        begin
            rank_next = rank_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            last_slot_reg <= '0;
            mode_reg      <= MODE_ZNZ;
            delta_reg     <= '0;
            thr_reg       <= '0;
            sv_reg        <= 1'b0;
            shv_reg       <= 1'b0;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_slot_reg <= last_slot_next;
            mode_reg      <= mode_next;
            delta_reg     <= delta_next;
            thr_reg       <= thr_next;
            sv_reg        <= sv_next;
            shv_reg       <= shv_next;
            p1_vld_reg    <= p1_vld_next;
            p2_vld_reg    <= p2_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        low_reg     <= low_next;
        high_reg    <= high_next;
        lval_reg    <= lval_next;
        obs_reg     <= obs_next;
        orig_reg    <= orig_next;
        scan_reg    <= scan_next;
        dup_reg     <= dup_next;
        less_reg    <= less_next;
        shift_reg   <= shift_next;
        sh_addr_reg <= sh_addr_next;
        rank_reg    <= rank_next;
        p1_last_reg <= p1_last_next;
        p2_last_reg <= p2_last_next;
        st_id_reg   <= st_id_next;
        st_code_reg <= st_code_next;
    end

    // entry words by slot: {id, low, high, list count}
    stvm_ram #(.WIDTH(SIG_W), .DEPTH(TABLE_DEPTH)) u_sig_ram (
        .clk     (clk),
        .wr_en   (sig_we),
        .wr_addr (sig_waddr),
        .wr_data (sig_wdata),
        .rd_en   (sig_re),
        .rd_addr (sig_raddr),
        .rd_data (sig_rdata)
    );

    // value lists, one row per slot
    stvm_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_list_ram (
        .clk     (clk),
        .wr_en   (lst_we),
        .wr_addr (lst_waddr),
        .wr_data (lst_wdata),
        .rd_en   (lst_re),
        .rd_addr (lst_raddr),
        .rd_data (lst_rdata)
    );

    // rank (id order) to slot
    stvm_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_DEPTH)) u_order_ram (
        .clk     (clk),
        .wr_en   (ord_we),
        .wr_addr (ord_waddr),
        .wr_data (ord_wdata),
        .rd_en   (ord_re),
        .rd_addr (ord_raddr),
        .rd_data (ord_rdata)
    );

    stvm_judge #(.LIST_DEPTH(LIST_DEPTH)) u_judge (
        .mode               (mode_reg),
        .fuzzy_delta        (delta_reg),
        .strategy_threshold (thr_reg),
        .lo                 (sig_lo),
        .hi                 (sig_hi),
        .obs                (obs_reg),
        .orig               (orig_reg),
        .list_count         (sig_cnt),
        .list_row           (lst_rdata),
        .verdict            (judged)
    );

    stvm_rq #(.DEPTH(RQ_DEPTH)) u_rq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rq_push),
        .push_data (rq_push_data),
        .pop       (!out_stall),
        .head      (rq_head),
        .not_empty (rq_not_empty),
        .count     (rq_count)
    );

    assign out_valid = rq_not_empty;
    assign result_id = rq_head.id;
    assign verdict   = rq_head.verdict;
    assign has_entry = rq_head.has_entry;
    assign status    = rq_head.status;
    assign last      = rq_head.last;

endmodule

`default_nettype wire

FILE: sv/stvm_ram.sv
// ----------------------------------------------------------------------------
// stvm_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module stvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/stvm_judge.sv
// ----------------------------------------------------------------------------
// stvm_judge
// Verdict of one stored signature against the observed value.
// ----------------------------------------------------------------------------
`default_nettype none

module stvm_judge
    import stvm_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    localparam int LCNT_W = $clog2(LIST_DEPTH + 1)
) (
    input  wire mode_t                    mode,
    input  wire logic [FUZZ_W-1:0]        fuzzy_delta,
    input  wire logic [FUZZ_W-1:0]        strategy_threshold,
    input  wire logic signed [VAL_W-1:0]  lo,
    input  wire logic signed [VAL_W-1:0]  hi,
    input  wire logic signed [VAL_W-1:0]  obs,
    input  wire logic signed [VAL_W-1:0]  orig,
    input  wire logic [LCNT_W-1:0]        list_count,
    input  wire logic [LIST_DEPTH*VAL_W-1:0] list_row,
    output verdict_t                      verdict
);

    logic signed [VAL_W:0] lo_x;
    logic signed [VAL_W:0] hi_x;
    logic signed [VAL_W:0] obs_x;
    logic signed [VAL_W:0] orig_x;
    logic signed [VAL_W:0] delta_x;
    logic signed [VAL_W:0] thr_x;
    logic signed [VAL_W:0] win_lo;
    logic signed [VAL_W:0] diff;
    logic                  list_hit;
    logic                  m;

    assign lo_x    = {lo[VAL_W-1], lo};
    assign hi_x    = {hi[VAL_W-1], hi};
    assign obs_x   = {obs[VAL_W-1], obs};
    assign orig_x  = {orig[VAL_W-1], orig};
    assign delta_x = {{(VAL_W + 1 - FUZZ_W){1'b0}}, fuzzy_delta};
    assign thr_x   = {{(VAL_W + 1 - FUZZ_W){1'b0}}, strategy_threshold};
    assign win_lo  = hi_x - delta_x;
    // exact in 33 bits for any pair of 32-bit operands
    assign diff    = obs_x - orig_x;

    always_comb
    begin
        list_hit = 1'b0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if ((LCNT_W'(i) < list_count) && (list_row[i*VAL_W +: VAL_W] == obs))
            begin
                list_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        m       = 1'b0;
        verdict = V_NONE;
        case (mode)
            MODE_ZNZ:
            begin
                m = ((obs == 0) && (lo == FLAG_ZERO)) || ((obs != 0) && (lo == FLAG_NONZERO));
                verdict = m ? V_MATCH : V_NO_MATCH;
            end
            MODE_ZNZ_ORIG:
            begin
                m = ((obs == 0) && (lo == FLAG_ZERO))
                    || ((obs != orig) && (obs != 0) && (lo == FLAG_NONZERO))
                    || ((obs == orig) && (lo == SENTINEL));
                verdict = m ? V_MATCH : V_NO_MATCH;
            end
            MODE_VALUE:
            begin
                m = (obs == lo) || ((obs != 0) && (lo == SENTINEL));
                verdict = m ? V_MATCH : V_NO_MATCH;
            end
            MODE_RANGE:
            begin
                // fuzzy window below the high bound when low is zero and high is at least the delta
                if ((lo == 0) && (hi_x >= delta_x))
                begin
                    m = (win_lo <= obs_x) && (obs_x <= hi_x);
                end
                else
                begin
                    m = (lo_x < obs_x) && (obs_x <= hi_x);
                end
                verdict = m ? V_MATCH : V_NO_MATCH;
            end
            MODE_INTERVAL:
            begin
                m = (lo_x < obs_x) && (obs_x < hi_x);
                verdict = m ? V_MATCH : V_NO_MATCH;
            end
            MODE_LIST:
            begin
                verdict = list_hit ? V_MATCH : V_NO_MATCH;
            end
            MODE_STRATEGY:
            begin
                if (((diff > thr_x) || (diff < 0)) && (lo == STRAT_RANDOM))
                begin
                    verdict = V_MATCH;
                end
                else if ((diff > 0) && (diff <= thr_x) && (lo == STRAT_INCR))
                begin
                    verdict = V_MATCH;
                end
                else if ((diff == 0) && (lo == STRAT_ZERO))
                begin
                    verdict = V_MATCH;
                end
                else
                begin
                    verdict = V_NONE;
                end
            end
            default:
            begin
                verdict = V_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/stvm_rq.sv
// ----------------------------------------------------------------------------
// stvm_rq
// Small result queue in front of the output port.
// ----------------------------------------------------------------------------
`default_nettype none

module stvm_rq
    import stvm_pkg::*;
#(
    parameter int DEPTH = RQ_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire result_t    push_data,
    input  wire logic       pop,
    output result_t         head,
    output logic            not_empty,
    output logic [CNT_W-1:0] count
);

    result_t          slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign head      = slots[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/stvm_checker.sv
// ----------------------------------------------------------------------------
// stvm_checker
// Port-level checks for the signature table value matcher.
// ----------------------------------------------------------------------------
`default_nettype none

module stvm_checker
    import stvm_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_stall,
    input wire logic [1:0]              command,
    input wire logic [ID_W-1:0]         entry_id,
    input wire logic signed [VAL_W-1:0] sig_low,
    input wire logic signed [VAL_W-1:0] sig_high,
    input wire logic signed [VAL_W-1:0] list_value,
    input wire logic signed [VAL_W-1:0] observed,
    input wire logic signed [VAL_W-1:0] original,
    input wire logic                    out_valid,
    input wire logic                    out_stall,
    input wire logic [ID_W-1:0]         result_id,
    input wire logic [1:0]              verdict,
    input wire logic                    has_entry,
    input wire logic [1:0]              status,
    input wire logic                    last,
    input wire logic                    cfg_valid,
    input wire logic                    cfg_ready,
    input wire logic [CFG_IDX_W-1:0]    cfg_index,
    input wire logic [CFG_DATA_W-1:0]   cfg_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_id) && $stable(verdict)
            && $stable(has_entry) && $stable(status) && $stable(last))
        else $error("stalled result beat changed");

    // status-only results carry no verdict and close their item
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_entry |-> (verdict == V_NONE) && last)
        else $error("malformed status result");

    // per-entry verdicts always report ok status
    a_entry_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_entry |-> (status == ST_OK))
        else $error("entry verdict with non-ok status");

    // an insert always keeps the block busy for the table search
    a_insert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (command == CMD_INSERT) |=> in_stall)
        else $error("insert beat not followed by busy");

endmodule

bind signature_table_value_matcher stvm_checker u_stvm_checker (.*);

`default_nettype wire

FILE: tb/tb_signature_table_value_matcher.sv
// ----------------------------------------------------------------------------
// tb_signature_table_value_matcher
// Self-checking bench: drives insert, append, observe and unused-command beats with
// random gaps and output stalls, predicts every result in-bench and compares them
// in order, across all match modes and a set of window and threshold settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_signature_table_value_matcher;
    import stvm_pkg::*;

    localparam int TBL_N  = 32;
    localparam int LIST_N = 8;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int MODE_SEVEN = 7;

    typedef struct {
        logic [1:0]        cmd;
        logic [ID_W-1:0]   id;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] lv;
        logic signed [31:0] obs;
        logic signed [31:0] orig;
    } beat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] command;
    logic [ID_W-1:0] entry_id;
    logic signed [VAL_W-1:0] sig_low, sig_high, list_value, observed, original;
    logic out_valid;
    logic out_stall;
    logic [ID_W-1:0] result_id;
    logic [1:0] verdict;
    logic has_entry;
    logic [1:0] status;
    logic last;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    signature_table_value_matcher u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .entry_id(entry_id), .sig_low(sig_low),
        .sig_high(sig_high), .list_value(list_value), .observed(observed),
        .original(original),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_id(result_id), .verdict(verdict), .has_entry(has_entry),
        .status(status), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow of the signature table
    logic [ID_W-1:0]    sh_id   [TBL_N];
    logic signed [31:0] sh_lo   [TBL_N];
    logic signed [31:0] sh_hi   [TBL_N];
    logic signed [31:0] sh_list [TBL_N][LIST_N];
    int                 sh_cnt  [TBL_N];
    int                 n_entries;
    int                 last_pos;
    logic [2:0]         cur_mode;
    logic [15:0]        cur_fuzzy;
    logic [15:0]        cur_thr;

    result_t expected_q[$];
    int      n_errors;
    bit      no_idle;
    int      rx_hold;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic void expect_result(input logic [ID_W-1:0] id, input verdict_t v,
                                          input logic he, input status_t st, input logic lst);
        result_t r;
        r.id        = id;
        r.verdict   = v;
        r.has_entry = he;
        r.status    = st;
        r.last      = lst;
        expected_q.push_back(r);
    endfunction

    function automatic verdict_t classify(input int e, input logic signed [31:0] ob,
                                          input logic signed [31:0] og);
        longint o, g, lo, hi, d, thr, diff;
        bit m;
        o   = ob;
        g   = og;
        lo  = sh_lo[e];
        hi  = sh_hi[e];
        d   = longint'(cur_fuzzy);
        thr = longint'(cur_thr);
        m   = 1'b0;
        case (cur_mode)
            MODE_ZNZ:
                m = (o == 0 && lo == 0) || (o != 0 && lo == 1);
            MODE_ZNZ_ORIG:
                m = (o == 0 && lo == 0) || (o != g && o != 0 && lo == 1)
                    || (o == g && lo == -1);
            MODE_VALUE:
                m = (o == lo) || (o != 0 && lo == -1);
            MODE_RANGE:
                if (lo == 0 && hi >= d)
                    m = (hi - d <= o) && (o <= hi);
                else
                    m = (lo < o) && (o <= hi);
            MODE_INTERVAL:
                m = (lo < o) && (o < hi);
            MODE_LIST:
                for (int i = 0; i < sh_cnt[e]; i++)
                    if (sh_list[e][i] == ob)
                        m = 1'b1;
            MODE_STRATEGY:
            begin
                diff = o - g;
                if ((diff > thr || diff < 0) && lo == 0)
                    return V_MATCH;
                if (diff > 0 && diff <= thr && lo == 1)
                    return V_MATCH;
                if (diff == 0 && lo == 2)
                    return V_MATCH;
                return V_NONE;
            end
            default:
                return V_NONE;
        endcase
        return m ? V_MATCH : V_NO_MATCH;
    endfunction

    function automatic void predict_beat(input beat_t b);
        int pos;
        if (b.cmd == CMD_INSERT) begin
            for (int i = 0; i < n_entries; i++)
                if (sh_id[i] == b.id) begin
                    expect_result(b.id, V_NONE, 1'b0, ST_DUPLICATE, 1'b1);
                    return;
                end
            if (n_entries >= TBL_N) begin
                expect_result(b.id, V_NONE, 1'b0, ST_TABLE_FULL, 1'b1);
                return;
            end
            pos = 0;
            while (pos < n_entries && sh_id[pos] < b.id)
                pos++;
            for (int i = n_entries; i > pos; i--) begin
                sh_id[i]   = sh_id[i-1];
                sh_lo[i]   = sh_lo[i-1];
                sh_hi[i]   = sh_hi[i-1];
                sh_cnt[i]  = sh_cnt[i-1];
                sh_list[i] = sh_list[i-1];
            end
            sh_id[pos]  = b.id;
            sh_lo[pos]  = b.lo;
            sh_hi[pos]  = b.hi;
            sh_cnt[pos] = 0;
            n_entries++;
            last_pos = pos;
            expect_result(b.id, V_NONE, 1'b0, ST_OK, 1'b1);
        end else if (b.cmd == CMD_APPEND) begin
            if (n_entries == 0)
                expect_result('0, V_NONE, 1'b0, ST_LIST_FULL, 1'b1);
            else if (sh_cnt[last_pos] >= LIST_N)
                expect_result(sh_id[last_pos], V_NONE, 1'b0, ST_LIST_FULL, 1'b1);
            else begin
                sh_list[last_pos][sh_cnt[last_pos]] = b.lv;
                sh_cnt[last_pos]++;
                expect_result(sh_id[last_pos], V_NONE, 1'b0, ST_OK, 1'b1);
            end
        end else if (b.cmd == CMD_OBSERVE) begin
            if (n_entries == 0)
                expect_result('0, V_NONE, 1'b0, ST_OK, 1'b1);
            else
                for (int i = 0; i < n_entries; i++)
                    expect_result(sh_id[i], classify(i, b.obs, b.orig), 1'b1, ST_OK,
                                  i == n_entries - 1);
        end
    endfunction

    function automatic int draw_gap();
        if (no_idle)
            return 0;
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
    endfunction

    // caller keeps in_valid high across back-to-back sends (same time step)
    task automatic send_beat(input beat_t b);
        int gap;
        bit ok;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= b.cmd;
        entry_id   <= b.id;
        sig_low    <= b.lo;
        sig_high   <= b.hi;
        list_value <= b.lv;
        observed   <= b.obs;
        original   <= b.orig;
        do begin
            @(negedge clk);
            ok = !in_stall;
            @(posedge clk);
        end while (!ok);
        predict_beat(b);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        // an unused command gives no result, so allow a full insert walk
        repeat (90) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        bit ok;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
        end while (!ok);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_MATCH_MODE: cur_mode  = val[2:0];
            CFG_FUZZY:      cur_fuzzy = val;
            default:        cur_thr   = val;
        endcase
    endtask

    function automatic beat_t noise_beat(input logic [1:0] cmd);
        beat_t b;
        b.cmd  = cmd;
        b.id   = ID_W'($urandom);
        b.lo   = $urandom;
        b.hi   = $urandom;
        b.lv   = $urandom;
        b.obs  = $urandom;
        b.orig = $urandom;
        return b;
    endfunction

    function automatic logic signed [31:0] pick_value();
        int e;
        e = (n_entries > 0) ? $urandom_range(0, n_entries - 1) : 0;
        case ($urandom_range(0, 11))
            0:  return 0;
            1:  return -1;
            2:  return 1;
            3:  return 32'h7fff_ffff;
            4:  return 32'h8000_0000;
            5:  return sh_lo[e] + $signed($urandom_range(0, 2)) - 1;
            6:  return sh_hi[e] + $signed($urandom_range(0, 2)) - 1;
            7:  return sh_hi[e] - $signed({16'b0, cur_fuzzy}) + $signed($urandom_range(0, 2)) - 1;
            8:  return (sh_cnt[e] > 0) ? sh_list[e][$urandom_range(0, sh_cnt[e] - 1)] : 0;
            9:  return $urandom_range(0, 40) - 20;
            default: return $urandom;
        endcase
    endfunction

    function automatic beat_t observe_beat();
        beat_t b;
        logic signed [31:0] diff;
        b = noise_beat(CMD_OBSERVE);
        b.obs = pick_value();
        case ($urandom_range(0, 6))
            0: diff = 0;
            1: diff = 1;
            2: diff = $signed({16'b0, cur_thr});
            3: diff = $signed({16'b0, cur_thr}) + 1;
            4: diff = -1;
            5: diff = $urandom_range(0, 70000);
            default: diff = $urandom;
        endcase
        b.orig = b.obs - diff;
        return b;
    endfunction

    function automatic beat_t insert_beat();
        beat_t b;
        b = noise_beat(CMD_INSERT);
        if ($urandom_range(0, 2) == 0)
            b.id = ID_W'($urandom_range(0, 60));
        case ($urandom_range(0, 5))
            0: b.lo = 0;
            1: b.lo = 1;
            2: b.lo = 2;
            3: b.lo = -1;
            4: b.lo = $urandom_range(0, 200) - 100;
            default: ;
        endcase
        if ($urandom_range(0, 1))
            b.hi = b.lo + $urandom_range(0, 70000);
        return b;
    endfunction

    // insert, a few appends, then observes; plus some noise
    task automatic run_mixed(input int n_items);
        beat_t b;
        int k;
        k = 0;
        while (k < n_items) begin
            case ($urandom_range(0, 9))
                0: begin
                    b = noise_beat(2'($urandom_range(0, 3)));
                    send_beat(b);
                    if (b.cmd != CMD_UNUSED)
                        k++;
                end
                1, 2: begin
                    send_beat(insert_beat());
                    k++;
                    repeat ($urandom_range(0, 4)) begin
                        b = noise_beat(CMD_APPEND);
                        if ($urandom_range(0, 1))
                            b.lv = pick_value();
                        send_beat(b);
                        k++;
                    end
                end
                default: begin
                    send_beat(observe_beat());
                    k++;
                end
            endcase
        end
        settle();
    endtask

    task automatic test_empty_table();
        send_beat(noise_beat(CMD_OBSERVE));
        send_beat(noise_beat(CMD_APPEND));
        send_beat(noise_beat(CMD_UNUSED));
        settle();
    endtask

    task automatic test_directed();
        beat_t b;
        logic signed [31:0] vals[4] = '{32'h7fff_ffff, 32'h8000_0000, 0, -1};
        b = noise_beat(CMD_INSERT); b.id = 16'd500;   b.lo = 0;  b.hi = 100;
        send_beat(b);
        b = noise_beat(CMD_INSERT); b.id = 16'd0;     b.lo = -1; b.hi = 32'h7fff_ffff;
        send_beat(b);
        b = noise_beat(CMD_INSERT); b.id = 16'hffff;  b.lo = 32'h8000_0000; b.hi = 0;
        send_beat(b);
        b = noise_beat(CMD_INSERT); b.id = 16'd500;   // duplicate id
        send_beat(b);
        b = noise_beat(CMD_INSERT); b.id = 16'd100;   b.lo = 1;  b.hi = 2;
        send_beat(b);
        // nine appends: the last overflows the list
        for (int i = 0; i < 9; i++) begin
            b = noise_beat(CMD_APPEND);
            if (i < 4)
                b.lv = vals[i];
            send_beat(b);
        end
        settle();
        for (int m = 0; m <= MODE_SEVEN; m++) begin
            write_reg(CFG_MATCH_MODE, 16'(m));
            b = noise_beat(CMD_OBSERVE); b.obs = 0; b.orig = 0;
            send_beat(b);
            b = noise_beat(CMD_OBSERVE); b.obs = 32'h8000_0000; b.orig = 32'h7fff_ffff;
            send_beat(b);
            settle();
        end
    endtask

    task automatic test_modes();
        logic [15:0] fz[4] = '{16'd0, 16'hffff, 16'd10, 16'd300};
        for (int m = 0; m <= MODE_SEVEN; m++) begin
            write_reg(CFG_MATCH_MODE, 16'(m));
            write_reg(CFG_FUZZY, fz[m % 4]);
            write_reg(CFG_THRESHOLD, fz[(m + 1) % 4]);
            no_idle = (m == 3);
            run_mixed(45);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_table_full();
        while (n_entries < TBL_N)
            send_beat(insert_beat());
        repeat (3) send_beat(insert_beat());
        settle();
        write_reg(CFG_MATCH_MODE, MODE_RANGE);
        run_mixed(20);
    endtask

    task automatic test_backpressure();
        write_reg(CFG_MATCH_MODE, MODE_LIST);
        rx_hold = 400;
        repeat (15) send_beat(observe_beat());
        settle();
    endtask

    // result side: random stalls, optional long hold, in-order compare
    initial begin
        result_t r, e;
        int g;
        bit got;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            if (rx_hold > 0) begin
                out_stall <= 1'b1;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            g = draw_gap();
            if (g > 0) begin
                out_stall <= 1'b1;
                repeat (g) @(posedge clk);
            end
            out_stall <= 1'b0;
            do begin
                @(negedge clk);
                got = out_valid;
                r.id        = result_id;
                r.verdict   = verdict_t'(verdict);
                r.has_entry = has_entry;
                r.status    = status_t'(status);
                r.last      = last;
                @(posedge clk);
            end while (!got);
            if (expected_q.size() == 0)
                report($sformatf("unexpected result id %0d", r.id));
            else begin
                e = expected_q.pop_front();
                if (r.id !== e.id)
                    report($sformatf("result_id %0d, want %0d", r.id, e.id));
                if (r.verdict !== e.verdict)
                    report($sformatf("verdict %0d, want %0d (id %0d)", r.verdict, e.verdict,
                                     e.id));
                if (r.has_entry !== e.has_entry)
                    report($sformatf("has_entry %0b, want %0b", r.has_entry, e.has_entry));
                if (r.status !== e.status)
                    report($sformatf("status %0d, want %0d", r.status, e.status));
                if (r.last !== e.last)
                    report($sformatf("last %0b, want %0b", r.last, e.last));
            end
        end
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = CMD_INSERT;
        entry_id   = '0;
        sig_low    = '0;
        sig_high   = '0;
        list_value = '0;
        observed   = '0;
        original   = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_MATCH_MODE;
        cfg_data   = '0;
        n_entries  = 0;
        last_pos   = 0;
        cur_mode   = MODE_ZNZ;
        cur_fuzzy  = '0;
        cur_thr    = '0;
        n_errors   = 0;
        no_idle    = 1'b0;
        rx_hold    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_directed();
        test_modes();
        test_table_full();
        test_backpressure();

        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/stvm_pkg.sv
sv/stvm_ram.sv
sv/stvm_judge.sv
sv/stvm_rq.sv
sv/signature_table_value_matcher.sv
sv/stvm_checker.sv
tb/tb_signature_table_value_matcher.sv
